/* hw/rtl/crcf_pkg.sv */
// Package with the frame constants and the CRC-32 byte update for the command framer.
package crcf_pkg;

   // Request actions
   localparam logic ACT_START   = 1'b0;   // start a new frame
   localparam logic ACT_PAYLOAD = 1'b1;   // deliver one payload byte

   // Reflected CRC-32 polynomial, initial value zero, no final xor
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   // Positions in the per-item result sequence
   localparam int SEQ_W = 4;
   localparam logic [SEQ_W-1:0] SEQ_FIRST = 4'd0;   // first sync byte
   localparam logic [SEQ_W-1:0] SEQ_LEN   = 4'd10;  // length byte
   localparam logic [SEQ_W-1:0] SEQ_TYPE  = 4'd11;  // type byte, or the payload byte
   localparam logic [SEQ_W-1:0] SEQ_CRC0  = 4'd12;  // lowest CRC byte
   localparam logic [SEQ_W-1:0] SEQ_END   = 4'd15;  // highest CRC byte

   // Sync header byte at a given position
   function automatic logic [7:0] sync_byte(input logic [SEQ_W-1:0] pos);
      logic [7:0] b;
      unique case (pos)
         4'd0:    b = 8'hFE;
         4'd1:    b = 8'hEF;
         4'd2:    b = 8'hDC;
         4'd3:    b = 8'hCD;
         4'd4:    b = 8'hBA;
         4'd5:    b = 8'hAB;
         4'd6:    b = 8'h98;
         4'd7:    b = 8'h89;
         4'd8:    b = 8'h76;
         4'd9:    b = 8'h67;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Fold one byte into the running CRC, one bit per step
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* hw/rtl/crcf_if.sv */
// Handshake interfaces for the request and response channels of the command framer.
interface crcf_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] cmd_kind;
   logic [7:0] payload_len;
   logic [7:0] data_byte;

   modport source (output valid, action, cmd_kind, payload_len, data_byte, input ready);
   modport sink   (input valid, action, cmd_kind, payload_len, data_byte, output ready);
endinterface

interface crcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;
   logic       rejected;
   logic       run_last;

   modport source (output valid, frame_byte, frame_end, rejected, run_last, input ready);
   modport sink   (input valid, frame_byte, frame_end, rejected, run_last, output ready);
endinterface

/* hw/rtl/crc32_command_framer.sv */
// Command frame builder: sync header, length, type, payload and CRC-32 as a byte stream.
//
// Usage:
//  req_bus (sink) takes one item per handshake: action 0 starts a frame with cmd_kind and
//  payload_len, action 1 delivers one payload byte (data_byte).
//  rsp_bus (source) gives one frame byte per handshake; run_last marks the last byte
//  caused by an item, frame_end the last CRC byte, rejected an out-of-sequence item.
//  The sequencer registers an accepted item, then the output register its first result.
//  Throughput: results leave at one per cycle while the receiver takes them. A start
//  item gives 12 results (16 with a zero length), a payload byte 1 result (5 for the
//  last one, which adds the CRC) and a rejected item 1 result; the single result
//  sequencer sets these figures. A new item is taken in the cycle the sequencer issues
//  the last result of the previous one. The CRC is updated by an unrolled byte step as
//  each frame byte before the CRC is issued. Reset (synchronous, active high) empties
//  the sequencer and output register and returns the framer to idle with a zero CRC.
//  When the receiver stalls the output register holds its result, the sequencer stops
//  and req_bus.ready falls once the sequencer holds an unfinished item.
module crc32_command_framer
   import crcf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   crcf_req_if.sink  req_bus,
   crcf_rsp_if.source rsp_bus
);

   // Frame state, updated when an item is taken
   logic             in_payload_ff, in_payload_in;
   logic [7:0]       left_ff, left_in;
   logic [31:0]      crc_ff, crc_in;

   // Sequencer holding the item at work
   logic             busy_ff, busy_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic             rej_ff, rej_in;
   logic             tail_ff, tail_in;   // issue the CRC after the type or payload byte
   logic [7:0]       len_ff, len_in;
   logic [7:0]       b11_ff, b11_in;     // type byte or payload byte

   // Output register
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_end_ff, out_end_in;
   logic             out_rej_ff, out_rej_in;
   logic             out_last_ff, out_last_in;

   logic             advance;
   logic             gen_last;
   logic             take;
   logic [7:0]       gen_byte;
   logic             start_ok;
   logic             data_ok;

   // Sequencer step and item handshake
   assign advance  = busy_ff && (!out_valid_ff || rsp_bus.ready);
   assign gen_last = rej_ff || (seq_ff == SEQ_TYPE && !tail_ff) || seq_ff == SEQ_END;
   assign req_bus.ready = !busy_ff || (advance && gen_last);
   assign take     = req_bus.valid && req_bus.ready;
   assign start_ok = (req_bus.action == ACT_START) && !in_payload_ff;
   assign data_ok  = (req_bus.action == ACT_PAYLOAD) && in_payload_ff;

   // Select the byte for the current sequence position
   always_comb begin
      if (seq_ff < SEQ_LEN) begin
         gen_byte = sync_byte(seq_ff);
      end else if (seq_ff == SEQ_LEN) begin
         gen_byte = len_ff;
      end else if (seq_ff == SEQ_TYPE) begin
         gen_byte = b11_ff;
      end else begin
         gen_byte = crc_ff[{seq_ff[1:0], 3'b000} +: 8];
      end
   end

   // Next state of frame tracking, sequencer and output register
   always_comb begin
      in_payload_in = in_payload_ff;
      left_in       = left_ff;
      crc_in        = crc_ff;
      busy_in       = busy_ff;
      seq_in        = seq_ff;
      rej_in        = rej_ff;
      tail_in       = tail_ff;
      len_in        = len_ff;
      b11_in        = b11_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_end_in    = out_end_ff;
      out_rej_in    = out_rej_ff;
      out_last_in   = out_last_ff;

      // drain the output register
      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      // issue one result and fold frame bytes into the CRC
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = rej_ff ? 8'd0 : gen_byte;
         out_end_in   = !rej_ff && seq_ff == SEQ_END;
         out_rej_in   = rej_ff;
         out_last_in  = gen_last;
         if (!rej_ff && seq_ff < SEQ_CRC0) begin
            crc_in = crc_byte((seq_ff == SEQ_FIRST) ? 32'd0 : crc_ff, gen_byte);
         end
         if (gen_last) begin
            busy_in = 1'b0;
         end else begin
            seq_in = seq_ff + 4'd1;
         end
      end

      // load a new item and update the frame state
      if (take) begin
         busy_in = 1'b1;
         len_in  = req_bus.payload_len;
         rej_in  = !(start_ok || data_ok);
         if (start_ok) begin
            seq_in  = SEQ_FIRST;
            b11_in  = req_bus.cmd_kind;
            tail_in = (req_bus.payload_len == 8'd0);
            if (req_bus.payload_len != 8'd0) begin
               in_payload_in = 1'b1;
               left_in       = req_bus.payload_len;
            end
         end else begin
            seq_in  = SEQ_TYPE;
            b11_in  = req_bus.data_byte;
            tail_in = (left_ff == 8'd1);
            if (data_ok) begin
               left_in = left_ff - 8'd1;
               if (left_ff == 8'd1) begin
                  in_payload_in = 1'b0;
               end
            end
         end
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         left_ff       <= 8'd0;
         crc_ff        <= 32'd0;
         busy_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_payload_ff <= in_payload_in;
         left_ff       <= left_in;
         crc_ff        <= crc_in;
         busy_ff       <= busy_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      rej_ff      <= rej_in;
      tail_ff     <= tail_in;
      len_ff      <= len_in;
      b11_ff      <= b11_in;
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
      out_rej_ff  <= out_rej_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.frame_byte = out_byte_ff;
   assign rsp_bus.frame_end  = out_end_ff;
   assign rsp_bus.rejected   = out_rej_ff;
   assign rsp_bus.run_last   = out_last_ff;

   // A new item only enters while the sequencer is empty or finishing
   a_take_when_free: assert property (@(posedge clock) disable iff (reset)
      (take && busy_ff) |-> (advance && gen_last))
      else $error("item taken while sequencer busy");

   // Rejected results are single and never close a frame
   a_reject_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.rejected) |-> (rsp_bus.run_last && !rsp_bus.frame_end))
      else $error("rejected result malformed");

   // The end of a frame is always the last result of its item
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.frame_end) |-> rsp_bus.run_last)
      else $error("frame end without run_last");

   // Idle framer expects no payload
   a_idle_no_left: assert property (@(posedge clock) disable iff (reset)
      !in_payload_ff |-> (left_ff == 8'd0))
      else $error("payload count left while idle");

endmodule
